@@ src/j2_oblateness_acceleration_core_assert.svh @@
`ifndef J2_OBLATENESS_ACCELERATION_CORE_ASSERT_SVH
`define J2_OBLATENESS_ACCELERATION_CORE_ASSERT_SVH

// The property must hold in the same cycle as its trigger.
`define J2OA_ASSERT_IMPLY(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("j2oa assertion failed");

// The property must hold in the cycle after its trigger.
`define J2OA_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("j2oa assertion failed");

`endif

@@ src/j2oa_pkg.sv @@
package j2oa_pkg;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ZERO_RADIUS = 2'd1;
    localparam logic [1:0] STATUS_SATURATED   = 2'd2;

    localparam logic [1:0] AXIS_Z = 2'd2;

    // Three times the default J2 of 4649860 in unsigned Q0.32.
    localparam logic [33:0] K_RESET = 34'd13949580;

    localparam logic [47:0] ACCEL_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACCEL_NEG_MIN = 48'h8000_0000_0000;

    localparam int SQ_STEPS = 32;
    localparam int W_QUO    = 60;
    localparam int T_QUO    = 62;
    localparam int A_QUO    = 48;

    typedef struct packed {
        logic [31:0] v_mag;
        logic        v_neg;
        logic [31:0] z_mag;
        logic [31:0] r2;
        logic [63:0] d3;
        logic        c_three;
        logic        r2_zero;
        logic        v_zero;
        logic        over;
        logic        s_neg;
        logic        g_neg;
    } side_t;

endpackage

@@ src/j2oa_in_if.sv @@
interface j2oa_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] component;
    logic signed [31:0] polar_coord;
    logic        [31:0] radius_squared;
    logic        [1:0]  axis;

    modport source (output valid, component, polar_coord, radius_squared, axis, input ready);
    modport sink (input valid, component, polar_coord, radius_squared, axis, output ready);
endinterface

@@ src/j2oa_out_if.sv @@
interface j2oa_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] accel;
    logic        [1:0]  status;

    modport source (output valid, accel, status, input ready);
    modport sink (input valid, accel, status, output ready);
endinterface

@@ src/j2oa_div.sv @@
module j2oa_div
    import j2oa_pkg::*;
#(
    parameter int NUM_W = 88,
    parameter int DEN_W = 32,
    parameter int QUO_W = 60
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  side_t            side_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic             over,
    output side_t            side_out
);

    localparam int CMP_W = NUM_W + DEN_W;

    logic [QUO_W:0]     valid_reg;
    logic [QUO_W:0]     over_reg;
    logic [DEN_W-1:0]   rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]   bits_reg [QUO_W+1];
    logic [DEN_W-1:0]   den_reg  [QUO_W+1];
    side_t              side_reg [QUO_W+1];

    logic [CMP_W-1:0]   head_ext;
    logic [CMP_W-1:0]   den_ext;
    logic               over_next;
    logic [DEN_W-1:0]   rem0_next;

    // The quotient fits in QUO_W bits exactly when the leading part is below the divisor.
    assign head_ext  = CMP_W'(num >> QUO_W);
    assign den_ext   = CMP_W'(den);
    assign over_next = head_ext >= den_ext;
    assign rem0_next = over_next ? '0 : DEN_W'(num >> QUO_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            over_reg    <= {over_reg[QUO_W-1:0], over_next};
            rem_reg[0]  <= rem0_next;
            bits_reg[0] <= num[QUO_W-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] bits_next;

        assign trial     = {rem_reg[k-1], bits_reg[k-1][QUO_W-1]};
        assign diff      = trial - {1'b0, den_reg[k-1]};
        assign take      = trial >= {1'b0, den_reg[k-1]};
        assign rem_next  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign bits_next = {bits_reg[k-1][QUO_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= bits_next;
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo       = bits_reg[QUO_W];
    assign over      = over_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

@@ src/j2_oblateness_acceleration_core.sv @@
// The latency from an accepted request to its result does not depend on FRAC_BITS.
// One request is accepted in every cycle; a stall at the output holds the whole pipeline.
// The depth is set by the 32-step square root and the 60-, 62- and 48-step dividers.
// Reset clears all valid bits and loads the default J2; payload registers are not reset.
`include "j2_oblateness_acceleration_core_assert.svh"

module j2_oblateness_acceleration_core
    import j2oa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    j2oa_in_if.sink     operand,
    j2oa_out_if.source  result,
    input  logic        wr_en,
    input  logic [31:0] wr_data
);

    localparam int ROOT_FRAC  = FRAC_BITS + (32 - FRAC_BITS) / 2;
    localparam int ROOT_SHIFT = 2 * ROOT_FRAC - FRAC_BITS;
    localparam int Z_SHIFT    = 32 - FRAC_BITS;
    localparam int T_SHIFT    = 33 - FRAC_BITS;
    localparam int W_NUM      = 64 + Z_SHIFT;
    localparam int T_NUM      = 97;
    localparam int T_DEN      = 32 + T_SHIFT;
    localparam int A_NUM      = 95 + ROOT_FRAC;
    localparam logic [62:0] ONE_Q32 = 63'd1 << 32;

    logic en;

    // Configuration: the register keeps three times J2.
    logic [33:0] k_reg;
    logic [33:0] k_next;

    assign k_next = {2'b00, wr_data} + {1'b0, wr_data, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (wr_en)
        begin
            k_reg <= k_next;
        end
    end

    // Input stage.
    logic [31:0] comp_raw;
    logic [31:0] z_raw;
    side_t       a_side_next;
    logic        a_valid_reg;
    side_t       a_side_reg;

    assign comp_raw = operand.component;
    assign z_raw    = operand.polar_coord;

    always_comb
    begin
        a_side_next         = '0;
        a_side_next.v_neg   = comp_raw[31];
        a_side_next.v_mag   = comp_raw[31] ? (~comp_raw + 32'd1) : comp_raw;
        a_side_next.z_mag   = z_raw[31] ? (~z_raw + 32'd1) : z_raw;
        a_side_next.r2      = operand.radius_squared;
        a_side_next.c_three = operand.axis == AXIS_Z;
        a_side_next.r2_zero = operand.radius_squared == 32'd0;
        a_side_next.v_zero  = comp_raw == 32'd0;
    end

    // Square root, one result bit per stage.
    logic [SQ_STEPS-1:0] sq_valid_reg;
    logic [63:0]         sq_x_reg    [SQ_STEPS];
    logic [63:0]         sq_r_reg    [SQ_STEPS];
    side_t               sq_side_reg [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] x_in;
        logic [63:0] r_in;
        side_t       s_in;
        logic [63:0] sum;
        logic        take;
        logic [63:0] x_next;
        logic [63:0] r_next;

        if (i == 0)
        begin : g_first
            assign x_in = 64'(a_side_reg.r2) << ROOT_SHIFT;
            assign r_in = '0;
            assign s_in = a_side_reg;
        end
        else
        begin : g_rest
            assign x_in = sq_x_reg[i-1];
            assign r_in = sq_r_reg[i-1];
            assign s_in = sq_side_reg[i-1];
        end

        assign sum    = r_in + BIT;
        assign take   = x_in >= sum;
        assign x_next = take ? (x_in - sum) : x_in;
        assign r_next = take ? ((r_in >> 1) + BIT) : (r_in >> 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_x_reg[i]    <= x_next;
                sq_r_reg[i]    <= r_next;
                sq_side_reg[i] <= s_in;
            end
        end
    end

    // d3 = r2 * r and z squared.
    logic [31:0] root;
    logic [63:0] b_d3_next;
    logic [63:0] b_z2_next;
    side_t       b_side_next;
    logic        b_valid_reg;
    side_t       b_side_reg;
    logic [63:0] b_z2_reg;

    assign root      = sq_r_reg[SQ_STEPS-1][31:0];
    assign b_d3_next = {32'b0, sq_side_reg[SQ_STEPS-1].r2} * {32'b0, root};
    assign b_z2_next = {32'b0, sq_side_reg[SQ_STEPS-1].z_mag} *
                       {32'b0, sq_side_reg[SQ_STEPS-1].z_mag};

    always_comb
    begin
        b_side_next    = sq_side_reg[SQ_STEPS-1];
        b_side_next.d3 = b_d3_next;
    end

    // w = z^2 / r2.
    logic             w_valid;
    logic [W_QUO-1:0] w_quo;
    logic             w_over;
    side_t            w_side;

    j2oa_div #(
        .NUM_W (W_NUM),
        .DEN_W (32),
        .QUO_W (W_QUO)
    ) u_w_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .num       ({b_z2_reg, {Z_SHIFT{1'b0}}}),
        .den       (b_side_reg.r2),
        .side_in   (b_side_reg),
        .out_valid (w_valid),
        .quo       (w_quo),
        .over      (w_over),
        .side_out  (w_side)
    );

    // s = 5w - c.
    logic [62:0] five_w;
    logic [62:0] offset;
    logic        s_neg;
    logic [62:0] c_smag_next;
    side_t       c_side_next;
    logic        c_valid_reg;
    side_t       c_side_reg;
    logic [62:0] c_smag_reg;

    assign five_w      = {1'b0, w_quo, 2'b00} + {3'b000, w_quo};
    assign offset      = w_side.c_three ? (63'd3 << 32) : ONE_Q32;
    assign s_neg       = five_w < offset;
    assign c_smag_next = s_neg ? (offset - five_w) : (five_w - offset);

    always_comb
    begin
        c_side_next       = w_side;
        c_side_next.over  = w_over;
        c_side_next.s_neg = s_neg;
    end

    // s * 3J2 in two partial products.
    logic        d_valid_reg;
    side_t       d_side_reg;
    logic [65:0] d_p0_reg;
    logic [30:0] d_shi_reg;
    logic [65:0] d_p0_next;

    logic        e_valid_reg;
    side_t       e_side_reg;
    logic [65:0] e_p0_reg;
    logic [64:0] e_p1_reg;
    logic [64:0] e_p1_next;

    logic        f_valid_reg;
    side_t       f_side_reg;
    logic [T_NUM-1:0] f_nt_reg;
    logic [T_NUM-1:0] f_nt_next;

    assign d_p0_next = 66'(c_smag_reg[31:0]) * 66'(k_reg);
    assign e_p1_next = 65'(d_shi_reg) * 65'(k_reg);
    assign f_nt_next = T_NUM'(e_p0_reg) + {e_p1_reg, 32'b0};

    // T = 3J2 * s / (2 * r2).
    logic             t_valid;
    logic [T_QUO-1:0] t_quo;
    logic             t_over;
    side_t            t_side;

    j2oa_div #(
        .NUM_W (T_NUM),
        .DEN_W (T_DEN),
        .QUO_W (T_QUO)
    ) u_t_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .num       (f_nt_reg),
        .den       ({f_side_reg.r2, {T_SHIFT{1'b0}}}),
        .side_in   (f_side_reg),
        .out_valid (t_valid),
        .quo       (t_quo),
        .over      (t_over),
        .side_out  (t_side)
    );

    // G = T - 1.
    logic [62:0] t_mag;
    logic [62:0] g_mag_next;
    logic        g_neg;
    side_t       g_side_next;
    logic        g_valid_reg;
    side_t       g_side_reg;
    logic [62:0] g_mag_reg;

    assign t_mag = 63'(t_quo);

    always_comb
    begin
        g_side_next = t_side;
        g_mag_next  = '0;
        g_neg       = 1'b0;
        if (t_side.over)
        begin
            g_neg = 1'b0;
        end
        else if (t_over)
        begin
            g_neg = t_side.s_neg;
        end
        else if (t_side.s_neg)
        begin
            g_neg      = 1'b1;
            g_mag_next = t_mag + ONE_Q32;
        end
        else
        begin
            g_neg      = t_mag < ONE_Q32;
            g_mag_next = g_neg ? (ONE_Q32 - t_mag) : (t_mag - ONE_Q32);
        end
        g_side_next.over  = t_side.over | t_over;
        g_side_next.g_neg = g_neg;
    end

    // v * G in two partial products.
    logic        h_valid_reg;
    side_t       h_side_reg;
    logic [63:0] h_p0_reg;
    logic [30:0] h_ghi_reg;
    logic [63:0] h_p0_next;

    logic        i_valid_reg;
    side_t       i_side_reg;
    logic [63:0] i_p0_reg;
    logic [62:0] i_p1_reg;
    logic [62:0] i_p1_next;

    logic        j_valid_reg;
    side_t       j_side_reg;
    logic [94:0] j_prod_reg;
    logic [94:0] j_prod_next;

    assign h_p0_next   = 64'(g_side_reg.v_mag) * 64'(g_mag_reg[31:0]);
    assign i_p1_next   = 63'(h_side_reg.v_mag) * 63'(h_ghi_reg);
    assign j_prod_next = 95'(i_p0_reg) + {i_p1_reg, 32'b0};

    // accel = v * G / d3.
    logic             q_valid;
    logic [A_QUO-1:0] q_quo;
    logic             q_over;
    side_t            q_side;

    j2oa_div #(
        .NUM_W (A_NUM),
        .DEN_W (64),
        .QUO_W (A_QUO)
    ) u_a_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (j_valid_reg),
        .num       ({j_prod_reg, {ROOT_FRAC{1'b0}}}),
        .den       (j_side_reg.d3),
        .side_in   (j_side_reg),
        .out_valid (q_valid),
        .quo       (q_quo),
        .over      (q_over),
        .side_out  (q_side)
    );

    // Output stage.
    logic        res_neg;
    logic        lim_over;
    logic [47:0] accel_next;
    logic [1:0]  status_next;
    logic        out_valid_reg;
    logic [47:0] out_accel_reg;
    logic [1:0]  out_status_reg;

    assign res_neg  = q_side.v_neg ^ q_side.g_neg;
    assign lim_over = res_neg ? (q_quo > ACCEL_NEG_MIN) : (q_quo > ACCEL_POS_MAX);

    always_comb
    begin
        if (q_side.r2_zero)
        begin
            accel_next  = '0;
            status_next = STATUS_ZERO_RADIUS;
        end
        else if (q_side.v_zero)
        begin
            accel_next  = '0;
            status_next = STATUS_OK;
        end
        else if (q_side.over || q_over || lim_over)
        begin
            accel_next  = res_neg ? ACCEL_NEG_MIN : ACCEL_POS_MAX;
            status_next = STATUS_SATURATED;
        end
        else
        begin
            accel_next  = res_neg ? (~q_quo + 48'd1) : q_quo;
            status_next = STATUS_OK;
        end
    end

    assign en            = !out_valid_reg || result.ready;
    assign operand.ready = en;
    assign result.valid  = out_valid_reg;
    assign result.accel  = out_accel_reg;
    assign result.status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            sq_valid_reg  <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= operand.valid;
            sq_valid_reg  <= {sq_valid_reg[SQ_STEPS-2:0], a_valid_reg};
            b_valid_reg   <= sq_valid_reg[SQ_STEPS-1];
            c_valid_reg   <= w_valid;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= t_valid;
            h_valid_reg   <= g_valid_reg;
            i_valid_reg   <= h_valid_reg;
            j_valid_reg   <= i_valid_reg;
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg     <= a_side_next;
            b_side_reg     <= b_side_next;
            b_z2_reg       <= b_z2_next;
            c_side_reg     <= c_side_next;
            c_smag_reg     <= c_smag_next;
            d_side_reg     <= c_side_reg;
            d_p0_reg       <= d_p0_next;
            d_shi_reg      <= c_smag_reg[62:32];
            e_side_reg     <= d_side_reg;
            e_p0_reg       <= d_p0_reg;
            e_p1_reg       <= e_p1_next;
            f_side_reg     <= e_side_reg;
            f_nt_reg       <= f_nt_next;
            g_side_reg     <= g_side_next;
            g_mag_reg      <= g_mag_next;
            h_side_reg     <= g_side_reg;
            h_p0_reg       <= h_p0_next;
            h_ghi_reg      <= g_mag_reg[62:32];
            i_side_reg     <= h_side_reg;
            i_p0_reg       <= h_p0_reg;
            i_p1_reg       <= i_p1_next;
            j_side_reg     <= i_side_reg;
            j_prod_reg     <= j_prod_next;
            out_accel_reg  <= accel_next;
            out_status_reg <= status_next;
        end
    end

    `J2OA_ASSERT_IMPLY(a_root_width, sq_valid_reg[SQ_STEPS-1], sq_r_reg[SQ_STEPS-1][63:32] == 32'd0)
    `J2OA_ASSERT_IMPLY(a_sat_at_limit, result.valid && (result.status == STATUS_SATURATED), (out_accel_reg == ACCEL_POS_MAX) || (out_accel_reg == ACCEL_NEG_MIN))
    `J2OA_ASSERT_IMPLY(a_zero_radius, result.valid && (result.status == STATUS_ZERO_RADIUS), out_accel_reg == 48'd0)
    `J2OA_ASSERT_NEXT(a_k_write, wr_en, k_reg == ({2'b00, $past(wr_data)} * 34'd3))

endmodule
